// ===== src/qhb_pkg.sv =====
// Package for the triquadratic hexahedron basis evaluator.
// Holds field types, fixed-point widths and the rounding and saturation helpers.
// No dependencies.
`default_nettype none

package qhb_pkg;

	localparam int FRAC_BITS = 14;
	localparam int COORD_W   = 16;
	localparam int SHAPE_W   = 16;
	localparam int GRAD_W    = 17;
	localparam int NODE_W    = 5;
	localparam int NODES     = 27;

	// 1D Lagrange terms and derivatives stay within +/-65536
	localparam int TERM_W  = COORD_W + 2;
	// coordinate times (coordinate +/- one)
	localparam int RAW_W   = 2 * COORD_W + 1;
	// term times term
	localparam int WIDE_W  = 2 * TERM_W;
	// two-factor products after rounding stay within +/-196608
	localparam int PAIR_W  = 20;
	localparam int PROD2_W = PAIR_W + TERM_W;
	localparam int FIN_W   = PROD2_W + 1 - FRAC_BITS;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [SHAPE_W-1:0] shape_t;
	typedef logic signed [GRAD_W-1:0]  grad_t;
	typedef logic        [NODE_W-1:0]  node_t;
	typedef logic signed [TERM_W-1:0]  term_t;
	typedef logic signed [RAW_W-1:0]   raw_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic signed [PAIR_W-1:0]  pair_t;
	typedef logic signed [PROD2_W-1:0] prod2_t;
	typedef logic signed [FIN_W-1:0]   fin_t;
	typedef logic        [1:0]         axis_idx_t;

	localparam node_t  LAST_NODE = NODE_W'(NODES - 1);
	localparam term_t  ONE       = TERM_W'(1 << FRAC_BITS);
	localparam term_t  HALF      = TERM_W'(1 << (FRAC_BITS - 1));
	localparam shape_t SHAPE_MAX = {1'b0, {(SHAPE_W-1){1'b1}}};
	localparam shape_t SHAPE_MIN = {1'b1, {(SHAPE_W-1){1'b0}}};
	localparam grad_t  GRAD_MAX  = {1'b0, {(GRAD_W-1){1'b1}}};
	localparam grad_t  GRAD_MIN  = {1'b1, {(GRAD_W-1){1'b0}}};

	// round to nearest, ties up, dropping s fractional bits
	function automatic term_t rnd_term(input raw_t p, input int s);
		logic signed [RAW_W:0] q;
		q = (RAW_W+1)'(p);
		q = q + (RAW_W+1)'(1 <<< (s - 1));
		return TERM_W'(q >>> s);
	endfunction

	function automatic pair_t rnd_pair(input wide_t p);
		logic signed [WIDE_W:0] q;
		q = (WIDE_W+1)'(p);
		q = q + (WIDE_W+1)'(1 <<< (FRAC_BITS - 1));
		return PAIR_W'(q >>> FRAC_BITS);
	endfunction

	function automatic fin_t rnd_fin(input prod2_t p);
		logic signed [PROD2_W:0] q;
		q = (PROD2_W+1)'(p);
		q = q + (PROD2_W+1)'(1 <<< (FRAC_BITS - 1));
		return FIN_W'(q >>> FRAC_BITS);
	endfunction

	function automatic shape_t sat_shape(input fin_t v);
		shape_t r;
		if (v > fin_t'(SHAPE_MAX)) begin
			r = SHAPE_MAX;
		end else if (v < fin_t'(SHAPE_MIN)) begin
			r = SHAPE_MIN;
		end else begin
			r = SHAPE_W'(v);
		end
		return r;
	endfunction

	function automatic grad_t sat_grad(input fin_t v);
		grad_t r;
		if (v > fin_t'(GRAD_MAX)) begin
			r = GRAD_MAX;
		end else if (v < fin_t'(GRAD_MIN)) begin
			r = GRAD_MIN;
		end else begin
			r = GRAD_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/qhb_pnt_if.sv =====
// Point channel: one reference coordinate triple per request.
// Depends on qhb_pkg.
`default_nettype none

interface qhb_pnt_if;
	import qhb_pkg::*;

	logic   valid;
	logic   ready;
	coord_t coord_x;
	coord_t coord_y;
	coord_t coord_z;

	modport source(output valid, output coord_x, output coord_y, output coord_z, input ready);
	modport sink(input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

`default_nettype wire

// ===== src/qhb_res_if.sv =====
// Result channel: one node's shape value and gradient per request.
// Depends on qhb_pkg.
`default_nettype none

interface qhb_res_if;
	import qhb_pkg::*;

	logic   valid;
	logic   ready;
	node_t  node_index;
	shape_t shape_value;
	grad_t  grad_x;
	grad_t  grad_y;
	grad_t  grad_z;
	logic   last_node;

	modport source(output valid, output node_index, output shape_value, output grad_x,
		output grad_y, output grad_z, output last_node, input ready);
	modport sink(input valid, input node_index, input shape_value, input grad_x,
		input grad_y, input grad_z, input last_node, output ready);
endinterface

`default_nettype wire

// ===== src/quadratic_hex_basis_eval.sv =====
// Triquadratic (27-node) hexahedron shape functions and reference gradients.
// Depends on qhb_pkg, qhb_pnt_if, qhb_res_if.
//
//   channel | dir | payload                                              | per point
//   point   | in  | coord_x, coord_y, coord_z (Q2.14)                    | 1
//   basis   | out | node_index, shape_value, grad_x/y/z, last_node      | 27
//
// One result leaves per cycle while basis is not stalled; the node
// sequencer walks i, j, k over the held axis terms to give 27 per point.
// Six register stages: point capture, axis table, two multiply/round pairs.
// After capture, a point's first result passes the axis table and node stages s3 to s6.
// The next point is taken into the capture stage while the table is walked.
// A stall on basis freezes all node stages; arst_n clears every valid bit.
`default_nettype none

module quadratic_hex_basis_eval (
	input  wire          clk,
	input  wire          arst_n,
	qhb_pnt_if.sink      point,
	qhb_res_if.source    basis
);
	import qhb_pkg::*;

	// point capture
	logic  v_s1;
	coord_t crd_s1 [3];
	raw_t  sq_s1 [3];
	raw_t  lo_s1 [3];
	raw_t  hi_s1 [3];

	// axis table, indexed [axis][node coordinate]
	logic  v_s2;
	term_t val_s2 [3][3];
	term_t der_s2 [3][3];

	// node sequencer
	axis_idx_t i_q, j_q, k_q;
	node_t     node_q;

	// node pipeline
	logic  v_s3, v_s4, v_s5, v_s6;
	wide_t pxy_s3, pdx_s3, pdy_s3;
	term_t lz_s3, dz_s3, lz_s4, dz_s4;
	pair_t xy_s4, dxly_s4, lxdy_s4;
	prod2_t shp_s5, gx_s5, gy_s5, gz_s5;
	node_t node_s3, node_s4, node_s5, node_s6;
	logic  last_s3, last_s4, last_s5, last_s6;
	shape_t shape_s6;
	grad_t  gx_s6, gy_s6, gz_s6;

	coord_t crd_in [3];
	logic   acc, adv, iss, last_iss, ld;

	assign crd_in[0] = point.coord_x;
	assign crd_in[1] = point.coord_y;
	assign crd_in[2] = point.coord_z;

	assign adv      = !v_s6 || basis.ready;
	assign iss      = v_s2 && adv;
	assign last_iss = iss && (node_q == LAST_NODE);
	assign ld       = v_s1 && (!v_s2 || last_iss);
	assign point.ready = !v_s1 || ld;
	assign acc      = point.valid && point.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc || (v_s1 && !ld);
			if (ld) begin
				v_s2 <= 1'b1;
			end else if (last_iss) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int a = 0; a < 3; a++) begin
				crd_s1[a] <= crd_in[a];
				sq_s1[a]  <= raw_t'(term_t'(crd_in[a]) * term_t'(crd_in[a]));
				lo_s1[a]  <= raw_t'(term_t'(crd_in[a]) * (term_t'(crd_in[a]) - ONE));
				hi_s1[a]  <= raw_t'(term_t'(crd_in[a]) * (term_t'(crd_in[a]) + ONE));
			end
		end
	end

	// halving in the outer terms folds into the rounding shift
	always_ff @(posedge clk) begin
		if (ld) begin
			for (int a = 0; a < 3; a++) begin
				val_s2[a][0] <= rnd_term(lo_s1[a], FRAC_BITS + 1);
				val_s2[a][1] <= ONE - rnd_term(sq_s1[a], FRAC_BITS);
				val_s2[a][2] <= rnd_term(hi_s1[a], FRAC_BITS + 1);
				der_s2[a][0] <= term_t'(crd_s1[a]) - HALF;
				der_s2[a][1] <= -(term_t'(crd_s1[a]) <<< 1);
				der_s2[a][2] <= term_t'(crd_s1[a]) + HALF;
			end
		end
	end

	// advance i fastest, then j, then k
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
			node_q <= '0;
		end else if (iss) begin
			if (last_iss) begin
				i_q    <= '0;
				j_q    <= '0;
				k_q    <= '0;
				node_q <= '0;
			end else begin
				node_q <= node_q + 1'b1;
				if (i_q == 2'd2) begin
					i_q <= '0;
					if (j_q == 2'd2) begin
						j_q <= '0;
						k_q <= k_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s3 <= iss;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pxy_s3  <= wide_t'(val_s2[0][i_q] * val_s2[1][j_q]);
			pdx_s3  <= wide_t'(der_s2[0][i_q] * val_s2[1][j_q]);
			pdy_s3  <= wide_t'(val_s2[0][i_q] * der_s2[1][j_q]);
			lz_s3   <= val_s2[2][k_q];
			dz_s3   <= der_s2[2][k_q];
			node_s3 <= node_q;
			last_s3 <= (node_q == LAST_NODE);

			xy_s4   <= rnd_pair(pxy_s3);
			dxly_s4 <= rnd_pair(pdx_s3);
			lxdy_s4 <= rnd_pair(pdy_s3);
			lz_s4   <= lz_s3;
			dz_s4   <= dz_s3;
			node_s4 <= node_s3;
			last_s4 <= last_s3;

			shp_s5  <= prod2_t'(xy_s4 * lz_s4);
			gx_s5   <= prod2_t'(dxly_s4 * lz_s4);
			gy_s5   <= prod2_t'(lxdy_s4 * lz_s4);
			gz_s5   <= prod2_t'(xy_s4 * dz_s4);
			node_s5 <= node_s4;
			last_s5 <= last_s4;

			shape_s6 <= sat_shape(rnd_fin(shp_s5));
			gx_s6    <= sat_grad(rnd_fin(gx_s5));
			gy_s6    <= sat_grad(rnd_fin(gy_s5));
			gz_s6    <= sat_grad(rnd_fin(gz_s5));
			node_s6  <= node_s5;
			last_s6  <= last_s5;
		end
	end

	assign basis.valid       = v_s6;
	assign basis.node_index  = node_s6;
	assign basis.shape_value = shape_s6;
	assign basis.grad_x      = gx_s6;
	assign basis.grad_y      = gy_s6;
	assign basis.grad_z      = gz_s6;
	assign basis.last_node   = last_s6;

endmodule

`default_nettype wire

// ===== src/qhb_checker.sv =====
// Port-level checks on the basis result stream, bound to the top level.
// Depends on qhb_pkg and quadratic_hex_basis_eval.
`default_nettype none

module qhb_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           out_valid,
	input wire           out_ready,
	input qhb_pkg::node_t node_index,
	input wire           last_node
);
	import qhb_pkg::*;

	// a pending result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_node == (node_index == LAST_NODE)))
		else $error("last_node does not match node 26");

	// nodes of a point leave in order with no gaps
	a_node_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_node |=>
			!out_valid || (node_index == NODE_W'($past(node_index) + 1'b1)))
		else $error("node_index out of sequence");

	a_node_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_node |=> !out_valid || (node_index == '0))
		else $error("next point does not start at node 0");

endmodule

bind quadratic_hex_basis_eval qhb_checker u_qhb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (basis.valid),
	.out_ready  (basis.ready),
	.node_index (basis.node_index),
	.last_node  (basis.last_node)
);

`default_nettype wire
